// ===== hw/rtl/text_mode_screen_writer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Text mode screen writer: assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_SCREEN_WRITER_UNIT_DEFINES_SVH
`define TEXT_MODE_SCREEN_WRITER_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define TMSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define TMSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always on (checks reset behavior)
`define TMSW_ASSERT_NEXT_ALL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tmsw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text mode screen writer package
// Geometry, field widths, codes and shared types.
// ----------------------------------------------------------------------------
package tmsw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 24;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
    localparam int LAST_CELL  = CELLS - 1;

    // widths
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int GLYPH_W  = 8;
    localparam int CODE_W   = 9;
    localparam int IDX_W    = 11;
    localparam int CURSOR_W = 11;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS + 1);
    localparam int POS_W    = ADDR_W + 1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // codes
    localparam logic [CODE_W-1:0]  CODE_NEWLINE   = 9'd10;
    localparam logic [CODE_W-1:0]  CODE_BACKSPACE = 9'h100;
    localparam logic [GLYPH_W-1:0] BLANK_GLYPH    = 8'h20;
    localparam logic [ATTR_W-1:0]  ATTR_RESET     = 8'h07;
    localparam logic               CMD_PUT        = 1'b0;
    localparam logic               CMD_READ       = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_ZERO,
        ST_BLANK,
        ST_READ,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  idx;
    } item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic                load;
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   data;
    } result_t;

endpackage

// ===== hw/rtl/text_mode_screen_writer_unit.sv =====
// ----------------------------------------------------------------------------
// Text mode screen writer
// 80x24 character-cell screen with cursor, put and cell-read words.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per command. s_tuser = 0 puts s_tdata char code at
//   the cursor (10 newline, 256 backspace, else glyph), s_tuser = 1 reads the
//   cell at s_tdata cell index. Every input word yields one m_ word carrying
//   the cursor after the command and, for reads, the cell (attribute:glyph).
//   cfg_we/cfg_wdata load the text attribute (reset 7); write only when idle.
// Timing:
//   Read or put without scroll: taken in IDLE, finished in READ or BLANK; a put
//   writes through the single cell RAM write port (glyph, then trailing blank).
//   Put that scrolls: a copy sweep of 23 rows through the RAM (SCROLL), zeroing
//   the bottom row (ZERO), then the blank.
//   m_tvalid rises from the output register once READ or BLANK is reached.
//   One command is in flight at a time; s_tready is high only when idle.
// Reset:
//   aresetn (sync, active low) homes the cursor and starts a clearing pass
//   over the cell RAM; s_tready stays low until it ends.
// Stall:
//   A finished result sits in the output register; if m_tready is low the
//   next result waits inside the sequencer and input is held off.
// ----------------------------------------------------------------------------
module text_mode_screen_writer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input commands
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tmsw_pkg::S_TDATA_W-1:0] s_tdata,  // [8:0] char_code, [19:9] cell_index
    input  logic                          s_tuser,  // [0] cmd
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tmsw_pkg::M_TDATA_W-1:0] m_tdata,  // [10:0] cursor_pos, [26:11] cell_data
    // attribute register
    input  logic                          cfg_we,
    input  logic [tmsw_pkg::ATTR_W-1:0]   cfg_wdata
);

    localparam int RES_W = tmsw_pkg::CURSOR_W + tmsw_pkg::CELL_W;

    tmsw_pkg::item_t    item;
    tmsw_pkg::mem_req_t mem_req;
    tmsw_pkg::result_t  res;

    logic [tmsw_pkg::ATTR_W-1:0]    attr_reg, attr_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [tmsw_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [tmsw_pkg::CELL_W-1:0]    rd_data;
    logic                           out_free;

    // unpack the input word
    assign item.cmd  = s_tuser;
    assign item.code = s_tdata[tmsw_pkg::CODE_W-1:0];
    assign item.idx  = s_tdata[tmsw_pkg::CODE_W +: tmsw_pkg::IDX_W];

    // output slot frees up when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    tmsw_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .item     (item),
        .attr     (attr_reg),
        .out_free (out_free),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .res      (res)
    );

    // screen cells
    tmsw_ram #(
        .WIDTH (tmsw_pkg::CELL_W),
        .DEPTH (tmsw_pkg::CELLS)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        attr_next     = cfg_we ? cfg_wdata : attr_reg;
        m_tvalid_next = res.load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = m_tdata_reg;
        if (res.load) begin
            m_tdata_next = {{(tmsw_pkg::M_TDATA_W - RES_W){1'b0}}, res.data, res.cursor};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg     <= tmsw_pkg::ATTR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            attr_reg     <= attr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/tmsw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/tmsw_seq.sv =====
// ----------------------------------------------------------------------------
// Text mode screen writer sequencer
// Cursor tracking, put/read decode, scroll and clear sweeps over the cell RAM.
// ----------------------------------------------------------------------------
module tmsw_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tmsw_pkg::item_t            item,
    input  logic [tmsw_pkg::ATTR_W-1:0] attr,
    input  logic                       out_free,
    output tmsw_pkg::mem_req_t         mem_req,
    input  logic [tmsw_pkg::CELL_W-1:0] rd_data,
    output tmsw_pkg::result_t          res
);

    tmsw_pkg::state_t state_reg, state_next;

    logic [tmsw_pkg::ADDR_W-1:0] pos_reg, pos_next;
    logic [tmsw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tmsw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tmsw_pkg::ADDR_W-1:0] swp_reg, swp_next;
    logic                        oob_reg, oob_next;
    logic [tmsw_pkg::CELL_W-1:0] cell_reg, cell_next;

    // cursor after a put, before any scroll
    logic [tmsw_pkg::POS_W-1:0]  put_pos;
    logic [tmsw_pkg::ROW_W-1:0]  put_row;
    logic [tmsw_pkg::COL_W-1:0]  put_col;
    logic                        put_wrap;
    logic                        is_plain;
    logic                        idx_ok;
    logic                        swp_last;
    logic                        swp_copy_end;
    logic [tmsw_pkg::CELL_W-1:0] read_cell;

    assign in_ready     = (state_reg == tmsw_pkg::ST_IDLE);
    assign is_plain     = (item.code != tmsw_pkg::CODE_NEWLINE) &&
                          (item.code != tmsw_pkg::CODE_BACKSPACE);
    assign idx_ok       = 32'(item.idx) < 32'(tmsw_pkg::CELLS);
    assign swp_last     = (swp_reg == tmsw_pkg::ADDR_W'(tmsw_pkg::LAST_CELL));
    assign swp_copy_end = (swp_reg == tmsw_pkg::ADDR_W'(tmsw_pkg::COPY_CELLS));
    assign read_cell    = oob_reg ? '0 : rd_data;
    assign put_wrap     = (put_row == tmsw_pkg::ROW_W'(tmsw_pkg::ROWS));

    always_comb begin
        put_pos = {1'b0, pos_reg};
        put_row = row_reg;
        put_col = col_reg;
        if (item.code == tmsw_pkg::CODE_NEWLINE) begin
            put_pos = {1'b0, pos_reg} + tmsw_pkg::POS_W'(tmsw_pkg::COLUMNS)
                      - tmsw_pkg::POS_W'(col_reg);
            put_row = row_reg + 1'b1;
            put_col = '0;
        end else if (item.code == tmsw_pkg::CODE_BACKSPACE) begin
            if (pos_reg != '0) begin
                put_pos = {1'b0, pos_reg} - 1'b1;
                if (col_reg == '0) begin
                    put_col = tmsw_pkg::COL_W'(tmsw_pkg::COLUMNS - 1);
                    put_row = row_reg - 1'b1;
                end else begin
                    put_col = col_reg - 1'b1;
                end
            end
        end else begin
            put_pos = {1'b0, pos_reg} + 1'b1;
            if (col_reg == tmsw_pkg::COL_W'(tmsw_pkg::COLUMNS - 1)) begin
                put_col = '0;
                put_row = row_reg + 1'b1;
            end else begin
                put_col = col_reg + 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmsw_pkg::ST_CLEAR: begin
                if (swp_last) state_next = tmsw_pkg::ST_IDLE;
            end
            tmsw_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (item.cmd == tmsw_pkg::CMD_READ) begin
                        state_next = tmsw_pkg::ST_READ;
                    end else if (put_wrap) begin
                        state_next = tmsw_pkg::ST_SCROLL;
                    end else begin
                        state_next = tmsw_pkg::ST_BLANK;
                    end
                end
            end
            tmsw_pkg::ST_SCROLL: begin
                if (swp_copy_end) state_next = tmsw_pkg::ST_ZERO;
            end
            tmsw_pkg::ST_ZERO: begin
                if (swp_last) state_next = tmsw_pkg::ST_BLANK;
            end
            tmsw_pkg::ST_BLANK,
            tmsw_pkg::ST_READ,
            tmsw_pkg::ST_HOLD: begin
                state_next = out_free ? tmsw_pkg::ST_IDLE : tmsw_pkg::ST_HOLD;
            end
            default: state_next = tmsw_pkg::ST_IDLE;
        endcase
    end

    // memory requests, result and datapath updates
    always_comb begin
        mem_req    = '0;
        res.load   = 1'b0;
        res.cursor = tmsw_pkg::CURSOR_W'(pos_reg);
        res.data   = cell_reg;
        pos_next   = pos_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        swp_next   = swp_reg;
        oob_next   = oob_reg;
        cell_next  = cell_reg;
        unique case (state_reg)
            tmsw_pkg::ST_CLEAR,
            tmsw_pkg::ST_ZERO: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = swp_reg;
                mem_req.wr_data = '0;
                swp_next        = swp_reg + 1'b1;
            end
            tmsw_pkg::ST_IDLE: begin
                swp_next = '0;
                if (in_valid) begin
                    if (item.cmd == tmsw_pkg::CMD_READ) begin
                        mem_req.rd_en   = idx_ok;
                        mem_req.rd_addr = tmsw_pkg::ADDR_W'(item.idx);
                        oob_next        = !idx_ok;
                    end else begin
                        mem_req.wr_en   = is_plain;
                        mem_req.wr_addr = pos_reg;
                        mem_req.wr_data = {attr, item.code[tmsw_pkg::GLYPH_W-1:0]};
                        if (put_wrap) begin
                            // scroll always lands at the start of the bottom row
                            pos_next = tmsw_pkg::ADDR_W'(tmsw_pkg::COPY_CELLS);
                            row_next = tmsw_pkg::ROW_W'(tmsw_pkg::ROWS - 1);
                            col_next = '0;
                        end else begin
                            pos_next = tmsw_pkg::ADDR_W'(put_pos);
                            row_next = put_row;
                            col_next = put_col;
                        end
                    end
                end
            end
            tmsw_pkg::ST_SCROLL: begin
                // read one row ahead, write the registered previous read one row up
                mem_req.rd_en   = !swp_copy_end;
                mem_req.rd_addr = swp_reg + tmsw_pkg::ADDR_W'(tmsw_pkg::COLUMNS);
                mem_req.wr_en   = (swp_reg != '0);
                mem_req.wr_addr = swp_reg - 1'b1;
                mem_req.wr_data = rd_data;
                swp_next        = swp_copy_end ? swp_reg : swp_reg + 1'b1;
            end
            tmsw_pkg::ST_BLANK: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                mem_req.wr_data = {attr, tmsw_pkg::BLANK_GLYPH};
                res.load        = out_free;
                res.data        = '0;
                cell_next       = '0;
            end
            tmsw_pkg::ST_READ: begin
                res.load  = out_free;
                res.data  = read_cell;
                cell_next = read_cell;
            end
            tmsw_pkg::ST_HOLD: begin
                res.load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tmsw_pkg::ST_CLEAR;
            pos_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            swp_reg   <= '0;
            oob_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            swp_reg   <= swp_next;
            oob_reg   <= oob_next;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

endmodule

// ===== hw/rtl/tmsw_checker.sv =====
// ----------------------------------------------------------------------------
// Text mode screen writer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_mode_screen_writer_unit_defines.svh"

module tmsw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tmsw_pkg::M_TDATA_W-1:0] m_tdata
);

    `TMSW_ASSERT_NEXT_ALL(a_reset_quiet, !aresetn, !m_tvalid && !s_tready, "reset not quiet")

    `TMSW_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second word taken early")

    `TMSW_ASSERT_NOW(a_cursor_range, m_tvalid,
        m_tdata[tmsw_pkg::CURSOR_W-1:0] < tmsw_pkg::CURSOR_W'(tmsw_pkg::CELLS),
        "cursor off screen")

    `TMSW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "stalled result changed")

endmodule

bind text_mode_screen_writer_unit tmsw_checker u_tmsw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
